// ----- rtl/brt_pkg.sv -----
`default_nettype none

package brt_pkg;

    // Operation codes carried on s_tuser
    localparam logic [1:0] FUNC_LOOKUP = 2'd0;
    localparam logic [1:0] FUNC_SWAP   = 2'd1;
    localparam logic [1:0] FUNC_CLEAR  = 2'd2;
    localparam logic [1:0] FUNC_RANGE  = 2'd3;

    // Field widths of the stream beats
    localparam int TID_W     = 2;
    localparam int IDX_W     = 10;
    localparam int CNT_W     = 11;
    localparam int FUNC_W    = 2;
    localparam int S_TDATA_W = 40;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 16;
    localparam int M_TUSER_W = 1;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load;
        logic check;
        logic rd_a;
        logic rd_b;
        logic wr_a;
        logic wr_b;
        logic fin_rd;
        logic fin_data;
        logic send;
        logic clr;
    } brt_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic err;
        logic is_pair;
        logic skip_loop;
        logic last_pair;
        logic rem_zero;
        logic clr_last;
        logic out_free;
    } brt_sts_t;

endpackage

`default_nettype wire

// ----- rtl/brt_ram.sv -----
`default_nettype none

module brt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge aclk) begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ----- rtl/brt_dpath.sv -----
`default_nettype none

module brt_dpath import brt_pkg::*; #(
    parameter int ENTRIES = 1024,
    parameter int TABLES  = 4
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire brt_cmd_t             cmd,
    output brt_sts_t                  sts,
    input  wire logic [S_TDATA_W-1:0] s_tdata,
    input  wire logic [S_TUSER_W-1:0] s_tuser,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic      [M_TDATA_W-1:0] m_tdata,
    output logic      [M_TUSER_W-1:0] m_tuser
);

    localparam int IW    = $clog2(ENTRIES);
    localparam int DEPTH = TABLES * ENTRIES;
    localparam int AW    = $clog2(DEPTH);
    localparam int DW    = 2 * IW + 2;
    localparam int VB    = DW - 1;
    localparam int CB    = DW - 2;
    localparam int CW    = (IW + 1 > IDX_W + 2) ? IW + 1 : IDX_W + 2;

    // Entry word layout: {valid, cached, prev, phys}
    function automatic logic [IW-1:0] eff_phys(input logic [DW-1:0] w, input logic [IW-1:0] ix);
        eff_phys = w[VB] ? w[IW-1:0] : ix;
    endfunction

    logic [FUNC_W-1:0] func_reg;
    logic [TID_W-1:0]  tid_reg;
    logic [IDX_W-1:0]  a_reg;
    logic [IDX_W-1:0]  b_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [AW-1:0]     base_reg;
    logic [IW-1:0]     ia_reg;
    logic [IW-1:0]     ib_reg;
    logic [CNT_W-1:0]  rem_reg;
    logic [IW-1:0]     eff_a_reg;
    logic [IW-1:0]     eff_b_reg;
    logic [IDX_W-1:0]  res_phys_reg;
    logic              res_cached_reg;
    logic              res_err_reg;
    logic [AW-1:0]     clr_addr_reg;
    logic [AW-1:0]     clr_addr_next;
    logic              m_tvalid_reg;
    logic              m_tvalid_next;
    logic [M_TDATA_W-1:0] m_tdata_reg;
    logic [M_TUSER_W-1:0] m_tuser_reg;

    logic [IW-1:0]     a_ix;
    logic [CW-1:0]     a_ext;
    logic [CW-1:0]     b_ext;
    logic [CW-1:0]     cnt_ext;
    logic [CW-1:0]     ent_c;
    logic              tid_bad;
    logic              a_bad;
    logic              b_bad;
    logic              r_bad;
    logic              fin_write;

    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [DW-1:0]     ram_wdata;
    logic [AW-1:0]     ram_raddr;
    logic [DW-1:0]     ram_rdata;

    logic [IW-1:0]     eff_now;
    logic [IW-1:0]     fin_prev;
    logic              fin_cache;

    assign a_ix    = IW'(a_reg);
    assign a_ext   = CW'(a_reg);
    assign b_ext   = CW'(b_reg);
    assign cnt_ext = CW'(cnt_reg);
    assign ent_c   = CW'(ENTRIES);

    // Range checks on the held item
    assign tid_bad = 32'(tid_reg) >= 32'(TABLES);
    assign a_bad   = a_ext >= ent_c;
    assign b_bad   = (func_reg == FUNC_SWAP) && (b_ext >= ent_c);
    assign r_bad   = (func_reg == FUNC_RANGE) &&
                     ((a_ext + cnt_ext > ent_c) || (b_ext + cnt_ext > ent_c));

    assign fin_write = (func_reg == FUNC_LOOKUP) || (func_reg == FUNC_CLEAR);

    // Status back to the controller
    always_comb begin
        sts.err       = tid_bad || a_bad || b_bad || r_bad;
        sts.is_pair   = (func_reg == FUNC_SWAP) || (func_reg == FUNC_RANGE);
        sts.skip_loop = (func_reg == FUNC_RANGE) && (cnt_reg == '0);
        sts.last_pair = rem_reg == CNT_W'(1);
        sts.rem_zero  = rem_reg == '0;
        sts.clr_last  = clr_addr_reg == AW'(DEPTH - 1);
        sts.out_free  = !m_tvalid_reg || m_tready;
    end

    // Capture the item and walk the pair indexes
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            func_reg <= s_tuser[1:0];
            tid_reg  <= s_tdata[1:0];
            a_reg    <= s_tdata[11:2];
            b_reg    <= s_tdata[21:12];
            cnt_reg  <= s_tdata[32:22];
            ia_reg   <= IW'(s_tdata[11:2]);
            ib_reg   <= IW'(s_tdata[21:12]);
        end else if (cmd.wr_b) begin
            ia_reg <= ia_reg + IW'(1);
            ib_reg <= ib_reg + IW'(1);
        end
    end

    // Table base and pair count
    always_ff @(posedge aclk) begin
        if (cmd.check) begin
            base_reg <= AW'(tid_reg) * AW'(ENTRIES);
            rem_reg  <= (func_reg == FUNC_SWAP) ? CNT_W'(1) : cnt_reg;
        end else if (cmd.wr_b) begin
            rem_reg <= rem_reg - CNT_W'(1);
        end
    end

    // Effective physical block of the word now on the read port
    always_comb begin
        eff_now   = eff_phys(ram_rdata, cmd.fin_data ? a_ix : (cmd.rd_b ? ia_reg : ib_reg));
        fin_prev  = ram_rdata[VB] ? ram_rdata[2*IW-1:IW] : a_ix;
        fin_cache = (func_reg == FUNC_CLEAR) ? 1'b0 : ram_rdata[CB];
    end

    // Hold the two old physical blocks of the pair
    always_ff @(posedge aclk) begin
        if (cmd.rd_b) begin
            eff_a_reg <= eff_now;
        end
        if (cmd.wr_a) begin
            eff_b_reg <= eff_now;
        end
    end

    // Result of the item
    always_ff @(posedge aclk) begin
        if (cmd.check && sts.err) begin
            res_phys_reg   <= '0;
            res_cached_reg <= 1'b0;
            res_err_reg    <= 1'b1;
        end else if (cmd.fin_data) begin
            res_phys_reg   <= IDX_W'(eff_now);
            res_cached_reg <= fin_cache;
            res_err_reg    <= 1'b0;
        end
    end

    // Read address select
    always_comb begin
        if (cmd.rd_b) begin
            ram_raddr = base_reg + AW'(ib_reg);
        end else if (cmd.fin_rd) begin
            ram_raddr = base_reg + AW'(a_ix);
        end else begin
            ram_raddr = base_reg + AW'(ia_reg);
        end
    end

    // Write port select: clearing pass, pair writes, final write of lookup and clear
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = clr_addr_reg;
        ram_wdata = '0;
        if (cmd.clr) begin
            ram_we = 1'b1;
        end else if (cmd.wr_a) begin
            ram_we    = 1'b1;
            ram_waddr = base_reg + AW'(ia_reg);
            ram_wdata = {1'b1, 1'b1, eff_a_reg, eff_now};
        end else if (cmd.wr_b) begin
            ram_we    = 1'b1;
            ram_waddr = base_reg + AW'(ib_reg);
            ram_wdata = {1'b1, 1'b1, eff_b_reg, eff_a_reg};
        end else if (cmd.fin_data && fin_write) begin
            ram_we    = 1'b1;
            ram_waddr = base_reg + AW'(a_ix);
            ram_wdata = {1'b1, fin_cache, fin_prev, eff_now};
        end
    end

    brt_ram #(
        .WIDTH (DW),
        .DEPTH (DEPTH)
    ) u_table (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Clearing pass address
    assign clr_addr_next = cmd.clr ? clr_addr_reg + AW'(1) : clr_addr_reg;

    // Output register: load on send, drop when the beat is taken
    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (cmd.send) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_addr_reg <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            clr_addr_reg <= clr_addr_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.send) begin
            m_tdata_reg <= {{(M_TDATA_W - IDX_W - 1){1'b0}}, res_cached_reg, res_phys_reg};
            m_tuser_reg <= res_err_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

`ifndef ASSERT_OFF
    // Every write outside the clearing pass leaves the entry initialized
    a_write_sets_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        (ram_we && !cmd.clr) |-> ram_wdata[VB])
        else $error("table write without initialized mark");
`endif

endmodule

`default_nettype wire

// ----- rtl/brt_ctrl.sv -----
`default_nettype none

module brt_ctrl import brt_pkg::*; (
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     s_tvalid,
    output logic          s_tready,
    input  wire brt_sts_t sts,
    output brt_cmd_t      cmd
);

    localparam logic [3:0] ST_CLEAR    = 4'd0;
    localparam logic [3:0] ST_IDLE     = 4'd1;
    localparam logic [3:0] ST_CHECK    = 4'd2;
    localparam logic [3:0] ST_RD_A     = 4'd3;
    localparam logic [3:0] ST_RD_B     = 4'd4;
    localparam logic [3:0] ST_WR_A     = 4'd5;
    localparam logic [3:0] ST_WR_B     = 4'd6;
    localparam logic [3:0] ST_FIN_RD   = 4'd7;
    localparam logic [3:0] ST_FIN_DATA = 4'd8;
    localparam logic [3:0] ST_RESP     = 4'd9;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    assign s_tready = state_reg == ST_IDLE;

    // Sequence one item: check, pair loop, final read, response
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_CLEAR: begin
                cmd.clr = 1'b1;
                if (sts.clr_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                cmd.check = 1'b1;
                if (sts.err) begin
                    state_next = ST_RESP;
                end else if (sts.is_pair && !sts.skip_loop) begin
                    state_next = ST_RD_A;
                end else begin
                    state_next = ST_FIN_RD;
                end
            end
            ST_RD_A: begin
                cmd.rd_a   = 1'b1;
                state_next = ST_RD_B;
            end
            ST_RD_B: begin
                cmd.rd_b   = 1'b1;
                state_next = ST_WR_A;
            end
            ST_WR_A: begin
                cmd.wr_a   = 1'b1;
                state_next = ST_WR_B;
            end
            ST_WR_B: begin
                cmd.wr_b   = 1'b1;
                state_next = sts.last_pair ? ST_FIN_RD : ST_RD_A;
            end
            ST_FIN_RD: begin
                cmd.fin_rd = 1'b1;
                state_next = ST_FIN_DATA;
            end
            ST_FIN_DATA: begin
                cmd.fin_data = 1'b1;
                state_next   = ST_RESP;
            end
            ST_RESP: begin
                if (sts.out_free) begin
                    cmd.send   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

`ifndef ASSERT_OFF
    // Leaving reset always starts the clearing pass
    a_reset_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(aresetn) |-> state_reg == ST_CLEAR)
        else $error("reset did not start clearing pass");

    // The first write of a pair follows the second read
    a_pair_order: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_WR_A) |-> ($past(state_reg) == ST_RD_B))
        else $error("pair write out of order");

    // A pair is never started with no pairs left
    a_pair_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_RD_A) |-> !sts.rem_zero)
        else $error("pair loop with zero count");

    // A result is only loaded when the output register can take it
    a_send_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.send |-> sts.out_free)
        else $error("result overwrote pending beat");
`endif

endmodule

`default_nettype wire

// ----- rtl/block_remap_table_core.sv -----
// Block remap table: TABLES tables of ENTRIES logical-to-physical entries.
// Input beats (s_) carry one command; each command yields one result beat (m_).
// s_tuser selects the command: lookup, swap pair, clear cached mark, swap range.
// An entry never set reads as identity and is made real on its first touch.
// Each item steps through a check, then (unless the check finds an error)
// the pair loop of a swap and a final read of the first entry, and last the
// response; the next beat is taken only back in the idle state after it.
// Each pair reads its two entries and then writes them, one after the other:
// the table has one read port and one write port.
// After reset the block sweeps all TABLES*ENTRIES entries (4096 at the
// defaults) once to clear the initialized and cached marks, with s_tready low.
// Results sit in an output register; while m_tready is low the result is held,
// the next beat is still accepted and worked, and its result waits to be sent.
`default_nettype none

module block_remap_table_core import brt_pkg::*; #(
    parameter int ENTRIES = 1024,
    parameter int TABLES  = 4
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    // [1:0] table_id, [11:2] first_index, [21:12] second_index, [32:22] count
    input  wire logic [S_TDATA_W-1:0] s_tdata,
    // [1:0] func
    input  wire logic [S_TUSER_W-1:0] s_tuser,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    // [9:0] phys_block, [10] cached
    output logic      [M_TDATA_W-1:0] m_tdata,
    // [0] range_error
    output logic      [M_TUSER_W-1:0] m_tuser
);

    brt_cmd_t cmd;
    brt_sts_t sts;

    brt_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    brt_dpath #(
        .ENTRIES (ENTRIES),
        .TABLES  (TABLES)
    ) u_dpath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .sts      (sts),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

`default_nettype wire
